>>> rtl/ols_pkg.sv
// Package: shared types and codes for the ordered list block.
`timescale 1ns / 1ps

package ols_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_PREPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

endpackage

>>> rtl/ols_ram.sv
// Entry store: simple dual-port RAM, one write and one registered read a cycle.
`timescale 1ns / 1ps

module ols_ram #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [ols_pkg::DATA_W-1:0] wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [ols_pkg::DATA_W-1:0] rdata
);

    logic signed [ols_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ordered_list_search_insert_delete_top.sv
// Append, full-list inserts and prepends, empty-list dumps and unknown operations
// give their result in the cycle after start; search, insert, delete and dump walk
// the list through the RAM read port; prepend and insert-after shift the tail up one
// entry a cycle; one transaction at a time, and busy stays high until the walk ends.
// Results show for one cycle on strobe; the receiver cannot stall them.
// Reset empties the list at once; the RAM itself is never cleared.
`timescale 1ns / 1ps

module ordered_list_search_insert_delete_top #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [ols_pkg::OP_W-1:0]               operation,
    input  logic signed [ols_pkg::DATA_W-1:0]      key,
    input  logic signed [ols_pkg::DATA_W-1:0]      value,
    output logic                                   strobe,
    output logic [ols_pkg::ST_W-1:0]               status,
    output logic signed [ols_pkg::DATA_W-1:0]      element,
    output logic                                   last,
    output logic [ols_pkg::COUNT_W-1:0]            entry_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ols_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                       count_reg, count_next;
    logic [CW-1:0]                       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                       w_reg, w_next;
    logic                                pend_reg, pend_next;
    logic [AW-1:0]                       pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                       pos_reg, pos_next;
    logic                                hit_reg, hit_next;
    logic [ols_pkg::OP_W-1:0]            op_reg, op_next;
    logic signed [ols_pkg::DATA_W-1:0]   key_reg, key_next;
    logic signed [ols_pkg::DATA_W-1:0]   value_reg, value_next;

    logic                                strobe_reg, strobe_next;
    logic [ols_pkg::ST_W-1:0]            status_reg, status_next;
    logic signed [ols_pkg::DATA_W-1:0]   element_reg, element_next;
    logic                                last_reg, last_next;
    logic [ols_pkg::COUNT_W-1:0]         entry_count_reg, entry_count_next;

    logic                                we;
    logic [AW-1:0]                       waddr;
    logic signed [ols_pkg::DATA_W-1:0]   wdata;
    logic                                re;
    logic [AW-1:0]                       raddr;
    logic signed [ols_pkg::DATA_W-1:0]   rdata;

    logic                                full;
    logic                                issue_scan;
    logic                                match;
    logic                                scan_done;
    logic                                shift_rd;
    logic [CW-1:0]                       rd_dec;

    ols_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign full       = (count_reg == CW'(DEPTH));
    assign issue_scan = (rd_ptr_reg < count_reg);
    assign match      = pend_reg && (rdata == key_reg);
    assign scan_done  = !issue_scan && !pend_reg;
    assign shift_rd   = (rd_ptr_reg > CW'(pos_reg));
    assign rd_dec     = rd_ptr_reg - 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ols_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        ols_pkg::OP_SEARCH, ols_pkg::OP_DELETE:
                            state_next = ols_pkg::S_SCAN;
                        ols_pkg::OP_DUMP:
                            if (count_reg != '0) state_next = ols_pkg::S_SCAN;
                        ols_pkg::OP_INSERT:
                            if (!full) state_next = ols_pkg::S_SCAN;
                        ols_pkg::OP_PREPEND:
                            if (!full) state_next = ols_pkg::S_SHIFT;
                        default:
                            state_next = ols_pkg::S_IDLE;
                    endcase
                end
            end
            ols_pkg::S_SCAN:
            begin
                if (match && (op_reg == ols_pkg::OP_SEARCH))
                    state_next = ols_pkg::S_IDLE;
                else if (match && (op_reg == ols_pkg::OP_INSERT))
                    state_next = ols_pkg::S_SHIFT;
                else if (scan_done)
                    state_next = ols_pkg::S_IDLE;
            end
            ols_pkg::S_SHIFT:
            begin
                if (!shift_rd && !pend_reg)
                    state_next = ols_pkg::S_IDLE;
            end
            default:
                state_next = ols_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result register
    always_comb
    begin
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        w_next       = w_reg;
        pend_next    = 1'b0;
        pend_idx_next = pend_idx_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        value_next   = value_reg;

        strobe_next  = 1'b0;
        status_next  = status_reg;
        element_next = element_reg;
        last_next    = last_reg;

        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = value;
        re    = 1'b0;
        raddr = rd_ptr_reg[AW-1:0];

        case (state_reg)
            ols_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    key_next    = key;
                    value_next  = value;
                    rd_ptr_next = '0;
                    w_next      = '0;
                    hit_next    = 1'b0;
                    case (operation)
                        ols_pkg::OP_SEARCH, ols_pkg::OP_DELETE:
                        begin
                        end
                        ols_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next  = 1'b1;
                                status_next  = ols_pkg::ST_EMPTY;
                                element_next = '0;
                                last_next    = 1'b1;
                            end
                        end
                        ols_pkg::OP_APPEND:
                        begin
                            strobe_next  = 1'b1;
                            element_next = '0;
                            last_next    = 1'b1;
                            if (full)
                            begin
                                status_next = ols_pkg::ST_FULL;
                            end
                            else
                            begin
                                we          = 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = ols_pkg::ST_OK;
                            end
                        end
                        ols_pkg::OP_INSERT, ols_pkg::OP_PREPEND:
                        begin
                            if (full)
                            begin
                                strobe_next  = 1'b1;
                                status_next  = ols_pkg::ST_FULL;
                                element_next = '0;
                                last_next    = 1'b1;
                            end
                            else if (operation == ols_pkg::OP_PREPEND)
                            begin
                                pos_next    = '0;
                                rd_ptr_next = count_reg;
                            end
                        end
                        default:
                        begin
                            strobe_next  = 1'b1;
                            status_next  = ols_pkg::ST_OK;
                            element_next = '0;
                            last_next    = 1'b1;
                        end
                    endcase
                end
            end

            ols_pkg::S_SCAN:
            begin
                // Issue the next read while the previous entry is examined
                re            = issue_scan;
                raddr         = rd_ptr_reg[AW-1:0];
                pend_next     = issue_scan;
                pend_idx_next = rd_ptr_reg[AW-1:0];
                if (issue_scan)
                    rd_ptr_next = rd_ptr_reg + 1'b1;

                case (op_reg)
                    ols_pkg::OP_SEARCH:
                    begin
                        if (match || scan_done)
                        begin
                            pend_next    = 1'b0;
                            strobe_next  = 1'b1;
                            status_next  = match ? ols_pkg::ST_OK : ols_pkg::ST_NOTFOUND;
                            element_next = '0;
                            last_next    = 1'b1;
                        end
                    end
                    ols_pkg::OP_INSERT:
                    begin
                        if (match)
                        begin
                            // Found the target: shift the tail up behind it
                            pend_next   = 1'b0;
                            pos_next    = pend_idx_reg + 1'b1;
                            rd_ptr_next = count_reg;
                        end
                        else if (scan_done)
                        begin
                            strobe_next  = 1'b1;
                            status_next  = ols_pkg::ST_NOTFOUND;
                            element_next = '0;
                            last_next    = 1'b1;
                        end
                    end
                    ols_pkg::OP_DELETE:
                    begin
                        // Compact survivors towards the head
                        if (match)
                        begin
                            hit_next = 1'b1;
                        end
                        else if (pend_reg)
                        begin
                            we     = 1'b1;
                            waddr  = w_reg[AW-1:0];
                            wdata  = rdata;
                            w_next = w_reg + 1'b1;
                        end
                        if (scan_done)
                        begin
                            count_next   = w_reg;
                            strobe_next  = 1'b1;
                            status_next  = hit_reg ? ols_pkg::ST_OK : ols_pkg::ST_NOTFOUND;
                            element_next = '0;
                            last_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (pend_reg)
                        begin
                            strobe_next  = 1'b1;
                            status_next  = ols_pkg::ST_OK;
                            element_next = rdata;
                            last_next    = (CW'(pend_idx_reg) == count_reg - 1'b1);
                        end
                    end
                endcase
            end

            ols_pkg::S_SHIFT:
            begin
                re            = shift_rd;
                raddr         = rd_dec[AW-1:0];
                pend_next     = shift_rd;
                pend_idx_next = rd_dec[AW-1:0];
                if (shift_rd)
                    rd_ptr_next = rd_dec;

                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_idx_reg + 1'b1;
                    wdata = rdata;
                end
                else if (!shift_rd)
                begin
                    // Gap is open: drop the new value in
                    we           = 1'b1;
                    waddr        = pos_reg;
                    wdata        = value_reg;
                    count_next   = count_reg + 1'b1;
                    strobe_next  = 1'b1;
                    status_next  = ols_pkg::ST_OK;
                    element_next = '0;
                    last_next    = 1'b1;
                end
            end

            default:
            begin
            end
        endcase

        entry_count_next = strobe_next ? ols_pkg::COUNT_W'(count_next) : entry_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ols_pkg::S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg      <= rd_ptr_next;
        w_reg           <= w_next;
        pend_idx_reg    <= pend_idx_next;
        pos_reg         <= pos_next;
        hit_reg         <= hit_next;
        op_reg          <= op_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        status_reg      <= status_next;
        element_reg     <= element_next;
        last_reg        <= last_next;
        entry_count_reg <= entry_count_next;
    end

    assign busy        = (state_reg != ols_pkg::S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign element     = element_reg;
    assign last        = last_reg;
    assign entry_count = entry_count_reg;

endmodule
